// ===== hdl/kct_pkg.sv =====
// Shared types and constants of the keyed change tracker.
package kct_pkg;

  localparam int SLOTS_DEF = 256;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_FIRST    = 3'd1;
  localparam logic [2:0] EV_CHANGE   = 3'd2;
  localparam logic [2:0] EV_LOST     = 3'd3;
  localparam logic [2:0] EV_REGAINED = 3'd4;

  // One sample as it travels from the front part to the back part
  typedef struct packed {
    logic [63:0] key;
    logic [25:0] snap;
    logic [63:0] link_word;
    logic [63:0] actor_id;
    logic [63:0] chain_word;
  } sample_t;

  // Result of one item
  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] slot_index;
    logic       evicted;
  } result_t;

endpackage

// ===== hdl/kct_front.sv =====
// Front part: accepts items, packs the snapshot and holds a two-entry queue.
module kct_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [63:0]      key,
  input  logic             granted,
  input  logic [7:0]       blocked_byte,
  input  logic             field_present,
  input  logic [7:0]       field_alive,
  input  logic [7:0]       actor_flag,
  input  logic [63:0]      link_word,
  input  logic [63:0]      actor_id,
  input  logic [63:0]      chain_word,
  output logic             q_valid,
  output kct_pkg::sample_t q_data,
  input  logic             q_take
);
  import kct_pkg::*;

  sample_t    fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  sample_t    s_in;

  // Pack the sample fields into the stored layout
  always_comb begin
    s_in.key        = key;
    s_in.snap       = {actor_flag, field_alive, field_present, blocked_byte, granted};
    s_in.link_word  = link_word;
    s_in.actor_id   = actor_id;
    s_in.chain_word = chain_word;
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_data  = fifo[rd_ptr];

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= s_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end

endmodule

// ===== hdl/kct_back.sv =====
// Back part: scans the slot memory, classifies the item and writes it back.
module kct_back #(
  parameter int SLOTS = kct_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  kct_pkg::sample_t q_data,
  output logic             q_take,
  output logic             res_valid,
  output kct_pkg::result_t res
);
  import kct_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0] LAST_C  = CW'(SLOTS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;

  // Slot memories
  logic [63:0] key_mem   [SLOTS];
  logic [63:0] seen_mem  [SLOTS];
  logic [26:0] flag_mem  [SLOTS];
  logic [63:0] link_mem  [SLOTS];
  logic [63:0] actor_mem [SLOTS];
  logic [63:0] chain_mem [SLOTS];

  logic [2:0]    state;
  logic [CW-1:0] used;
  logic [63:0]   tick;
  logic [CW-1:0] scan;
  logic          rd_ok;
  logic [AW-1:0] rd_idx;
  logic [63:0]   rd_key;
  logic [63:0]   rd_seen;
  logic [26:0]   rd_flag;
  logic [63:0]   rd_link;
  logic [63:0]   rd_actor;
  logic [63:0]   rd_chain;
  logic          found;
  logic [AW-1:0] hit_idx;
  logic [AW-1:0] old_idx;
  logic [63:0]   old_seen;
  logic          old_ok;
  sample_t       cur;
  logic [AW-1:0] rd_addr;
  logic          differs;
  logic          lost_now;
  logic [2:0]    kind;
  logic          was_ok;

  assign rd_addr = (state == S_READ) ? hit_idx : scan[AW-1:0];

  // Registered memory read
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_seen  <= seen_mem[rd_addr];
    rd_flag  <= flag_mem[rd_addr];
    rd_link  <= link_mem[rd_addr];
    rd_actor <= actor_mem[rd_addr];
    rd_chain <= chain_mem[rd_addr];
  end

  // Classify against the stored snapshot
  always_comb begin
    was_ok   = rd_flag[0];
    differs  = (rd_flag[25:0] != cur.snap) || (rd_link != cur.link_word)
            || (rd_actor != cur.actor_id) || (rd_chain != cur.chain_word);
    lost_now = rd_flag[26];
    kind     = EV_NONE;
    if (differs) begin
      priority if (was_ok && !cur.snap[0]) begin
        kind = EV_LOST;  lost_now = 1'b1;
      end else if (!was_ok && cur.snap[0] && rd_flag[26]) begin
        kind = EV_REGAINED;  lost_now = 1'b0;
      end else begin
        kind = EV_CHANGE;
      end
    end
  end

  assign q_take = (state == S_IDLE) && q_valid;

  // Sequencer with memory writes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      state <= S_CLEAR;
      scan  <= '0;
      used  <= '0;
      tick  <= '0;
    end else begin
      res_valid <= (state == S_DEC);
      unique case (state)
        S_CLEAR: begin
          seen_mem[scan[AW-1:0]] <= '0;
          if (scan == LAST_C) begin
            state <= S_IDLE;
          end
          scan <= scan + 1'b1;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_data;
            tick     <= tick + 64'd1;
            scan     <= '0;
            rd_ok    <= 1'b0;
            found    <= 1'b0;
            old_ok   <= 1'b0;
            old_idx  <= '0;
            old_seen <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // compare the slot read last cycle
          if (rd_ok && !found) begin
            if (rd_idx < used[AW-1:0] || used == SLOTS_C) begin
              if (rd_key == cur.key) begin
                found <= 1'b1; hit_idx <= rd_idx;
              end
            end
            if (!old_ok || rd_seen < old_seen) begin
              old_ok <= 1'b1; old_idx <= rd_idx; old_seen <= rd_seen;
            end
          end
          rd_idx <= scan[AW-1:0];
          rd_ok  <= (scan < used) && !found;
          if (scan == SLOTS_C || found) begin
            if (found || (rd_ok && (rd_key == cur.key))) begin
              state <= S_READ;
            end else begin
              state <= S_DEC;
            end
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_READ: begin
          state <= S_DEC;
        end
        S_DEC: begin
          state     <= S_IDLE;
          if (found) begin
            seen_mem[hit_idx] <= tick;
            if (differs) begin
              flag_mem[hit_idx]  <= {lost_now, cur.snap};
              link_mem[hit_idx]  <= cur.link_word;
              actor_mem[hit_idx] <= cur.actor_id;
              chain_mem[hit_idx] <= cur.chain_word;
            end
            res.event_kind <= kind;
            res.slot_index <= 8'(hit_idx);
            res.evicted    <= 1'b0;
          end else begin
            res.event_kind <= EV_FIRST;
            if (used < SLOTS_C) begin
              key_mem[used[AW-1:0]]   <= cur.key;
              seen_mem[used[AW-1:0]]  <= tick;
              flag_mem[used[AW-1:0]]  <= {1'b0, cur.snap};
              link_mem[used[AW-1:0]]  <= cur.link_word;
              actor_mem[used[AW-1:0]] <= cur.actor_id;
              chain_mem[used[AW-1:0]] <= cur.chain_word;
              res.slot_index <= 8'(used);
              res.evicted    <= 1'b0;
              used <= used + 1'b1;
            end else begin
              key_mem[old_idx]   <= cur.key;
              seen_mem[old_idx]  <= tick;
              flag_mem[old_idx]  <= {1'b0, cur.snap};
              link_mem[old_idx]  <= cur.link_word;
              actor_mem[old_idx] <= cur.actor_id;
              chain_mem[old_idx] <= cur.chain_word;
              res.slot_index <= 8'(old_idx);
              res.evicted    <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/keyed_change_tracker_lru.sv =====
// Top level of the keyed change tracker with oldest-entry replacement.
// Usage: drive a sample on the input ports with start high; it is taken at
// an edge where busy is low. A two-entry queue holds taken samples for the
// back part, which scans the slot memory once per item, matching the key
// among filled slots and tracking the oldest tick at the same time.
// The back part handles one item at a time through the single read port of
// the slot memory; while it works, the queue takes new samples until it is full.
// The result (event_kind, slot_index, evicted) appears for one cycle with
// done high; the receiver cannot stall, so it must take it then.
// Reset: rst synchronous, active high. After reset a clearing pass over all
// SLOTS slots zeroes the tick memory; samples are queued meanwhile (busy rises
// when the queue is full) and processed once the pass ends.
module keyed_change_tracker_lru #(
  parameter int SLOTS = kct_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] key,
  input  logic        granted,
  input  logic [7:0]  blocked_byte,
  input  logic        field_present,
  input  logic [7:0]  field_alive,
  input  logic [7:0]  actor_flag,
  input  logic [63:0] link_word,
  input  logic [63:0] actor_id,
  input  logic [63:0] chain_word,
  output logic        done,
  output logic [2:0]  event_kind,
  output logic [7:0]  slot_index,
  output logic        evicted
);
  import kct_pkg::*;

  logic    q_valid;
  logic    q_take;
  sample_t q_data;
  result_t res;

  // Accept and queue samples
  kct_front u_front (
    .clk, .rst, .start, .busy, .key, .granted, .blocked_byte, .field_present,
    .field_alive, .actor_flag, .link_word, .actor_id, .chain_word,
    .q_valid, .q_data, .q_take
  );

  // Look up, classify and write back
  kct_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_take, .res_valid(done), .res
  );

  assign event_kind = res.event_kind;
  assign slot_index = res.slot_index;
  assign evicted    = res.evicted;

endmodule
